// ===== sv/bnr_pkg.sv =====
// Shared constants and types for the byte/nibble RAM with copy and fill.
// No dependencies; every other file imports this package.
package bnr_pkg;

    localparam int RAM_BYTES = 65536;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int ACT_W     = 3;
    localparam int ADDR_W    = 18;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 17;
    localparam int CMP_W     = ((ADDR_W > RAM_AW + 2) ? ADDR_W : RAM_AW + 2) + 1;

    localparam logic [ACT_W-1:0] ACT_BYTE_RD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NIB_RD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BYTE_WR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NIB_WR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_COPY    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FILL    = 3'd5;

    typedef struct packed {
        logic load;
        logic nwr;
        logic blk;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] in_act;
        logic             blk_zero;
        logic             blk_done;
    } t_sts;

endpackage

// ===== sv/bnr_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on bnr_pkg for field widths.
interface bnr_in_if import bnr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] source_address;
    logic [DATA_W-1:0] write_value;
    logic [LEN_W-1:0]  length;

    modport source (output valid, action, address, source_address, write_value, length,
                    input ready);
    modport sink   (input valid, action, address, source_address, write_value, length,
                    output ready);
endinterface

interface bnr_out_if import bnr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// ===== sv/bnr_ctrl.sv =====
// Sequencer for the byte/nibble RAM: handshakes and per-action steps.
// Depends on bnr_pkg; drives commands into bnr_dp.
module bnr_ctrl import bnr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NWR  = 2'd1;
    localparam logic [1:0] S_BLK  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       accept;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_ovalid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_act == ACT_NIB_WR) begin
                        n_state = S_NWR;
                    end else if ((i_sts.in_act == ACT_COPY || i_sts.in_act == ACT_FILL)
                                 && !i_sts.blk_zero) begin
                        n_state = S_BLK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_NWR: begin
                o_cmd.nwr = 1'b1;
                n_state   = S_FIN;
            end
            S_BLK: begin
                if (i_sts.blk_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.blk = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (o_cmd.fin) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== sv/bnr_dp.sv =====
// Datapath for the byte/nibble RAM: memory array, range checks, block counters.
// Depends on bnr_pkg; commanded by bnr_ctrl.
module bnr_dp import bnr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_source_address,
    input  logic [DATA_W-1:0] i_write_value,
    input  logic [LEN_W-1:0]  i_length,
    output logic [DATA_W-1:0] o_read_data
);

    localparam logic [CMP_W-1:0] RAM_C = CMP_W'(RAM_BYTES);
    localparam logic [CMP_W-1:0] NIB_C = CMP_W'(2 * RAM_BYTES);

    logic [DATA_W-1:0] mem [RAM_BYTES];

    logic [ACT_W-1:0]  r_act;
    logic              r_lsb;
    logic              r_inr;
    logic [RAM_AW-1:0] r_dst;
    logic [RAM_AW-1:0] r_src;
    logic [DATA_W-1:0] r_val;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_pend;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_out;

    logic [CMP_W-1:0]  addr_ext, src_ext, len_ext, hi, limit;
    logic              nib_act, byte_ok, nib_ok, start_ok, in_ok;
    logic [RAM_AW-1:0] byte_idx, nib_idx, in_idx;
    logic [LEN_W-1:0]  n_len;
    logic              is_copy, issue;
    logic              we, re;
    logic [RAM_AW-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, merged, result;

    assign addr_ext = CMP_W'(i_address);
    assign src_ext  = CMP_W'(i_source_address);
    assign len_ext  = CMP_W'(i_length);
    assign byte_idx = addr_ext[RAM_AW-1:0];
    assign nib_idx  = addr_ext[RAM_AW:1];
    assign byte_ok  = addr_ext < RAM_C;
    assign nib_ok   = addr_ext < NIB_C;
    assign nib_act  = (i_action == ACT_NIB_RD) || (i_action == ACT_NIB_WR);
    assign in_idx   = nib_act ? nib_idx : byte_idx;
    assign in_ok    = nib_act ? nib_ok : byte_ok;

    assign start_ok = byte_ok && ((i_action != ACT_COPY) || (src_ext < RAM_C));
    assign hi       = (i_action == ACT_COPY && src_ext > addr_ext) ? src_ext : addr_ext;
    assign limit    = RAM_C - hi;
    assign n_len    = !start_ok ? '0 : ((len_ext < limit) ? i_length : LEN_W'(limit));

    assign is_copy  = (r_act == ACT_COPY);
    assign issue    = (r_cnt != '0);
    assign merged   = r_lsb ? {r_rdata[7:4], r_val[3:0]} : {r_val[3:0], r_rdata[3:0]};

    assign o_sts.in_act   = i_action;
    assign o_sts.blk_zero = (n_len == '0);
    assign o_sts.blk_done = !issue && !r_pend;

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_dst;
        raddr = r_src;
        wdata = r_val;
        if (i_cmd.load) begin
            we    = (i_action == ACT_BYTE_WR) && byte_ok;
            waddr = byte_idx;
            wdata = i_write_value;
            re    = 1'b1;
            raddr = in_idx;
        end else if (i_cmd.nwr) begin
            we    = r_inr;
            wdata = merged;
        end else if (i_cmd.blk) begin
            if (is_copy) begin
                we    = r_pend;
                wdata = r_rdata;
                re    = issue;
            end else begin
                we    = issue;
            end
        end
    end

    always_comb begin
        case (r_act)
            ACT_BYTE_RD: result = r_inr ? r_rdata : '0;
            ACT_NIB_RD: begin
                if (!r_inr) begin
                    result = '0;
                end else begin
                    result = r_lsb ? {4'h0, r_rdata[3:0]} : {4'h0, r_rdata[7:4]};
                end
            end
            default: result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_pend <= 1'b0;
        end else if (i_cmd.blk) begin
            r_pend <= is_copy && issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_lsb <= i_address[0];
            r_inr <= in_ok;
            r_dst <= in_idx;
            r_src <= src_ext[RAM_AW-1:0];
            r_val <= i_write_value;
            r_cnt <= n_len;
        end else if (i_cmd.blk) begin
            if (issue) begin
                r_cnt <= r_cnt - LEN_W'(1);
            end
            if (is_copy) begin
                if (issue) begin
                    r_src <= r_src + RAM_AW'(1);
                end
                if (r_pend) begin
                    r_dst <= r_dst + RAM_AW'(1);
                end
            end else if (issue) begin
                r_dst <= r_dst + RAM_AW'(1);
            end
        end
        if (i_cmd.fin) begin
            r_out <= result;
        end
    end

    assign o_read_data = r_out;

endmodule

// ===== sv/byte_nibble_ram_copy_fill.sv =====
// Byte-wide RAM with byte/nibble read and write, block copy and block fill.
// Reads, byte writes, unused codes, empty or skipped blocks go from accept to the result state.
// Nibble write passes through a merge-and-write state first. Copy of n >= 1 bytes and fill
// pass through the block state (one byte per cycle); a new word is accepted only while idle,
// which starts in the same cycle as the result becomes valid. Output stalls hold the controller.
// Synchronous active-low reset clears control only; memory is undefined until written.
module byte_nibble_ram_copy_fill import bnr_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    bnr_in_if.sink  i_in,
    bnr_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    bnr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bnr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_in.action),
        .i_address        (i_in.address),
        .i_source_address (i_in.source_address),
        .i_write_value    (i_in.write_value),
        .i_length         (i_in.length),
        .o_read_data      (o_out.read_data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
